// ===== hdl/id_allocator_free_stack_macros.svh =====
// Assertion macros for the identifier allocator.
// Used by the top-level allocator module, which carries the concurrent assertions; expects clk and arst_n in scope.
`ifndef ID_ALLOCATOR_FREE_STACK_MACROS_SVH
`define ID_ALLOCATOR_FREE_STACK_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define IDFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define IDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/idfs_pkg.sv =====
// Shared types and codes for the identifier allocator.
// No dependencies; imported by every module of the block.
package idfs_pkg;

	localparam int ID_W = 16;
	localparam int STATUS_W = 3;

	typedef logic [STATUS_W-1:0] status_t;

	// Result codes.
	localparam status_t STAT_ALLOCATED = 3'd0;
	localparam status_t STAT_NONE_FREE = 3'd1;
	localparam status_t STAT_RELEASED = 3'd2;
	localparam status_t STAT_OUT_OF_RANGE = 3'd3;
	localparam status_t STAT_NOT_IN_USE = 3'd4;

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Operation of the shared adder.
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_EXEC = 2'b10
	} seq_state_t;

	// Commit controls from the sequencer to the store.
	typedef struct packed {
		logic pop;
		logic push;
		logic map_set;
		logic map_clr;
	} store_ctl_t;

endpackage

// ===== hdl/idfs_alu.sv =====
// Shared 17-bit add/subtract unit of the identifier allocator.
// Depends on idfs_pkg for the operation code.
module idfs_alu
	import idfs_pkg::*;
(
	input  alu_op_t            op,
	input  logic [ID_W:0]      a,
	input  logic [ID_W:0]      b,
	output logic [ID_W:0]      y
);

	// One adder; subtraction by two's complement of the second operand.
	always_comb begin
		case (op)
			ALU_SUB: y = a + ~b + (ID_W+1)'(1);
			default: y = a + b;
		endcase
	end

endmodule

// ===== hdl/idfs_store.sv =====
// Free stack memory, in-use map memory and stack pointers of the allocator.
// Depends on idfs_pkg; untouched entries are tracked by a low-water mark.
module idfs_store
	import idfs_pkg::*;
#(
	parameter int ID_COUNT = 4096,
	localparam int OFF_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1,
	localparam int CNT_W = $clog2(ID_COUNT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [OFF_W-1:0] rd_off,
	input  store_ctl_t       ctl,
	input  logic [OFF_W-1:0] wr_off,
	output logic             empty,
	output logic [OFF_W-1:0] pop_off,
	output logic             in_use
);

	logic [OFF_W-1:0] stk_mem [ID_COUNT];
	logic             map_mem [ID_COUNT];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] low_q;
	logic [CNT_W-1:0] cnt_dec;
	logic [OFF_W-1:0] top_idx;
	logic [OFF_W-1:0] stk_rd_q;
	logic [OFF_W-1:0] top_idx_q;
	logic             hit_low_q;
	logic             map_rd_q;
	logic             map_vld_q;
	logic             full;

	assign cnt_dec = count_q - CNT_W'(1);
	assign top_idx = cnt_dec[OFF_W-1:0];
	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(ID_COUNT));

	// Entries below the low-water mark were never written and still hold their
	// own index; a map bit below it was never set.
	assign pop_off = hit_low_q ? top_idx_q : stk_rd_q;
	assign in_use = map_vld_q & map_rd_q;

	// Registered reads, taken when a word is accepted and held until the next.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			stk_rd_q <= stk_mem[top_idx];
			top_idx_q <= top_idx;
			hit_low_q <= (count_q == low_q);
			map_rd_q <= map_mem[rd_off];
			map_vld_q <= (CNT_W'(rd_off) >= low_q);
		end
	end

	// Memory writes at commit.
	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			stk_mem[count_q[OFF_W-1:0]] <= wr_off;
		end
		if (ctl.map_set || ctl.map_clr) begin
			map_mem[wr_off] <= ctl.map_set;
		end
	end

	// Stack pointer and low-water mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(ID_COUNT);
			low_q <= CNT_W'(ID_COUNT);
		end else if (ctl.pop && !empty) begin
			count_q <= cnt_dec;
			if (count_q == low_q) begin
				low_q <= cnt_dec;
			end
		end else if (ctl.push && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

endmodule

// ===== hdl/id_allocator_free_stack.sv =====
// Identifier allocator with a LIFO free stack and an in-use bitmap.
// Each word is accepted in the idle state and its result is registered in the execute
// state once the output register is free; no new word is accepted until then, as the
// shared adder and the registered memory reads of the sequencer serve one word at a time.
// A full output register holds the sequencer in execute. Reset is immediate: no clearing pass,
// every id is free and the highest id is handed out first.
module id_allocator_free_stack
	import idfs_pkg::*;
#(
	parameter int ID_COUNT = 4096,
	localparam int OFF_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            req_type,
	input  logic [ID_W-1:0] release_id,
	output logic            out_valid,
	input  logic            out_stall,
	output status_t         status,
	output logic [ID_W-1:0] granted_id
);

`include "id_allocator_free_stack_macros.svh"

	seq_state_t       state_q;
	logic [ID_W-1:0]  base_q;
	logic             req_q;
	logic             in_range_q;
	logic [OFF_W-1:0] off_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [ID_W-1:0]  granted_q;

	logic             accept;
	logic             out_free;
	logic             commit;
	alu_op_t          alu_op;
	logic [ID_W:0]    alu_a;
	logic [ID_W:0]    alu_b;
	logic [ID_W:0]    alu_y;
	logic             in_range;
	store_ctl_t       ctl;
	logic [OFF_W-1:0] wr_off;
	logic             empty;
	logic [OFF_W-1:0] pop_off;
	logic             in_use;
	status_t          status_d;
	logic [ID_W-1:0]  granted_d;

	assign in_stall = (state_q != SEQ_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign commit = (state_q == SEQ_EXEC) && out_free;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign granted_id = granted_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// The shared adder subtracts the base on accept and adds it back on commit.
	always_comb begin
		if (state_q == SEQ_IDLE) begin
			alu_op = ALU_SUB;
			alu_a = {1'b0, release_id};
			alu_b = {1'b0, base_q};
		end else begin
			alu_op = ALU_ADD;
			alu_a = {1'b0, base_q};
			alu_b = (ID_W+1)'(pop_off);
		end
	end

	idfs_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// A borrow means the id lies below the base.
	assign in_range = !alu_y[ID_W] && (alu_y[ID_W-1:0] < ID_W'(ID_COUNT));

	// Request registers captured on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			in_range_q <= in_range;
			off_q <= alu_y[OFF_W-1:0];
		end
	end

	// Result and store controls for the request under execution.
	always_comb begin
		ctl = '0;
		status_d = STAT_NONE_FREE;
		granted_d = '0;
		wr_off = off_q;
		if (req_q == REQ_ALLOC) begin
			wr_off = pop_off;
			if (!empty) begin
				ctl.pop = commit;
				ctl.map_set = commit;
				status_d = STAT_ALLOCATED;
				granted_d = alu_y[ID_W-1:0];
			end
		end else if (!in_range_q) begin
			status_d = STAT_OUT_OF_RANGE;
		end else if (!in_use) begin
			status_d = STAT_NOT_IN_USE;
		end else begin
			ctl.push = commit;
			ctl.map_clr = commit;
			status_d = STAT_RELEASED;
		end
	end

	idfs_store #(
		.ID_COUNT (ID_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_off  (alu_y[OFF_W-1:0]),
		.ctl     (ctl),
		.wr_off  (wr_off),
		.empty   (empty),
		.pop_off (pop_off),
		.in_use  (in_use)
	);

	// Sequencer: accept, then execute once the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			unique case (state_q)
				SEQ_IDLE: begin
					if (accept) begin
						state_q <= SEQ_EXEC;
					end
				end
				SEQ_EXEC: begin
					if (out_free) begin
						state_q <= SEQ_IDLE;
					end
				end
				default: state_q <= SEQ_IDLE;
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			granted_q <= granted_d;
		end
	end

	`IDFS_ASSERT_NEXT(a_accept_exec, accept, state_q == SEQ_EXEC, "accepted word did not enter execute")
	`IDFS_ASSERT_NOW(a_zero_grant, out_valid && status != STAT_ALLOCATED, granted_id == '0, "nonzero id on a non-allocate result")
	`IDFS_ASSERT_NOW(a_status_code, out_valid, status_q <= STAT_NOT_IN_USE, "undefined status code")
	`IDFS_ASSERT_NEXT(a_commit_valid, commit, out_valid_q, "commit did not load the output register")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the identifier allocator with a LIFO free stack.
// Depends on idfs_pkg and id_allocator_free_stack; a tracker class predicts every answer.
module testbench;
	import idfs_pkg::*;

	localparam int ID_COUNT = 4096;
	localparam int OFF_W = 12;

	// One expected answer: status code and granted identifier.
	typedef struct packed {
		status_t         st;
		logic [ID_W-1:0] id;
	} id_answer_t;

	// Tracks the free stack, the in-use map and the base, and checks the answers in order.
	class id_pool_tracker;
		bit [ID_W-1:0]  base;
		bit [OFF_W-1:0] free_offsets[ID_COUNT];
		int unsigned    free_count;
		bit             in_use[ID_COUNT];
		id_answer_t     due_answers[$];
		int             errors;

		function new();
			for (int i = 0; i < ID_COUNT; i++) begin
				free_offsets[i] = OFF_W'(i);
				in_use[i] = 1'b0;
			end
			free_count = ID_COUNT;
			base = '0;
			errors = 0;
		endfunction

		function void set_base(bit [ID_W-1:0] value);
			base = value;
		endfunction

		function int unsigned pending();
			return due_answers.size();
		endfunction

		// Works out the answer to one accepted request and updates the pool.
		function void note_request(logic rq, logic [ID_W-1:0] rid);
			id_answer_t  ans;
			int unsigned off;
			int unsigned req_id;
			int unsigned b;
			ans.id = '0;
			req_id = rid;
			b = base;
			if (rq == REQ_ALLOC) begin
				if (free_count == 0) begin
					ans.st = STAT_NONE_FREE;
				end else begin
					free_count--;
					off = free_offsets[free_count];
					in_use[off] = 1'b1;
					ans.id = ID_W'(b + off);
					ans.st = STAT_ALLOCATED;
				end
			end else if (req_id < b || req_id - b >= ID_COUNT) begin
				ans.st = STAT_OUT_OF_RANGE;
			end else begin
				off = req_id - b;
				if (!in_use[off]) begin
					ans.st = STAT_NOT_IN_USE;
				end else begin
					in_use[off] = 1'b0;
					if (free_count < ID_COUNT) begin
						free_offsets[free_count] = OFF_W'(off);
						free_count++;
					end
					ans.st = STAT_RELEASED;
				end
			end
			due_answers.push_back(ans);
		endfunction

		// Compares one accepted result word with the oldest expected answer.
		function void check_answer(status_t st, logic [ID_W-1:0] gid);
			id_answer_t ans;
			if (due_answers.size() == 0) begin
				$error("result word with no request outstanding: status %0d granted_id %0d",
					st, gid);
				errors++;
				return;
			end
			ans = due_answers.pop_front();
			if (st !== ans.st) begin
				$error("status: expected %0d, got %0d", ans.st, st);
				errors++;
			end
			if (gid !== ans.id) begin
				$error("granted_id: expected %0d, got %0d", ans.id, gid);
				errors++;
			end
		endfunction

		// Returns an identifier currently in use, or a random one when none is.
		function logic [ID_W-1:0] pick_in_use();
			int unsigned start;
			int unsigned off;
			start = $urandom_range(0, ID_COUNT - 1);
			for (int k = 0; k < ID_COUNT; k++) begin
				off = (start + k) % ID_COUNT;
				if (in_use[off])
					return ID_W'(base + off);
			end
			return ID_W'($urandom);
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wr_en = 1'b0;
	logic [ID_W-1:0] cfg_wr_data = '0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic            req_type = REQ_ALLOC;
	logic [ID_W-1:0] release_id = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	status_t         status;
	logic [ID_W-1:0] granted_id;

	id_pool_tracker pool = new();

	// Sender burst state and the long hold-off requests for the receiver.
	int burst_left = 0;
	int hold_requests = 0;

	id_allocator_free_stack #(.ID_COUNT(ID_COUNT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.release_id(release_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_id(granted_id)
	);

	always #5 clk = ~clk;

	// Offers one request word, opening a new burst after a random gap when needed.
	task automatic send_word(input logic rq, input logic [ID_W-1:0] rid);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= rq;
		release_id <= rid;
		do @(posedge clk); while (in_stall);
		pool.note_request(rq, rid);
	endtask

	task automatic send_alloc();
		send_word(REQ_ALLOC, ID_W'($urandom));
	endtask

	// Stops offering words and waits, with a limit, until every answer has arrived.
	task automatic wait_drained();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pool.pending() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		if (pool.pending() != 0)
			$error("%0d answers still outstanding", pool.pending());
		repeat (4) @(posedge clk);
	endtask

	// Writes the base register while the block is idle.
	task automatic write_base(input logic [ID_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pool.set_base(value);
	endtask

	// One random request: mostly well-formed traffic, the rest noise.
	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_alloc();
		else if (r < 80)
			send_word(REQ_RELEASE, pool.pick_in_use());
		else if (r < 90)
			send_word(REQ_RELEASE, ID_W'(pool.base + $urandom_range(0, ID_COUNT - 1)));
		else
			send_word(REQ_RELEASE, ID_W'($urandom));
	endtask

	// Receiver: checks accepted result words and stalls on its own segment pattern.
	int seg_left = 0;
	int seg_kind = 0;
	int hold_left = 0;
	int hold_served = 0;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			pool.check_answer(status, granted_id);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = 100;
			out_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(1, 20);
				seg_kind = $urandom_range(0, 3);
			end
			seg_left--;
			case (seg_kind)
				2: out_stall <= 1'b1;
				3: out_stall <= ($urandom_range(0, 9) < 4);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Run limit.
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	// Main stimulus sequence.
	initial begin
		logic [ID_W-1:0] phase_bases[4];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state, base zero: window edges, release of a free id, LIFO reuse.
		send_word(REQ_RELEASE, 16'd0);
		send_word(REQ_RELEASE, 16'd4096);
		send_word(REQ_RELEASE, 16'hFFFF);
		send_alloc();
		send_alloc();
		send_word(REQ_RELEASE, 16'd4095);
		send_word(REQ_RELEASE, 16'd4095);
		send_alloc();
		send_word(REQ_RELEASE, 16'd4094);

		// Highest legal base; the id still in use moves with the base.
		write_base(16'd61439);
		send_word(REQ_RELEASE, 16'd61438);
		send_word(REQ_RELEASE, 16'hFFFF);
		send_word(REQ_RELEASE, 16'd65534);
		send_alloc();
		send_word(REQ_RELEASE, 16'd61439);
		send_word(REQ_RELEASE, 16'd0);

		// Window past the top of the id space: granted ids wrap and cannot be released.
		write_base(16'hFFF0);
		send_alloc();
		send_alloc();
		send_word(REQ_RELEASE, 16'h0FEE);
		send_word(REQ_RELEASE, 16'hFFFF);
		send_word(REQ_RELEASE, 16'hFFF0);

		// A run of allocations under a random base, then a stray release.
		write_base(16'd0);
		write_base(ID_W'($urandom_range(0, 61439)));
		for (int i = 0; i < 40; i++)
			send_alloc();
		send_word(REQ_RELEASE, ID_W'($urandom));

		// Random traffic under several bases.
		phase_bases[0] = 16'd0;
		phase_bases[1] = 16'd61439;
		phase_bases[2] = ID_W'($urandom_range(0, 61439));
		phase_bases[3] = ID_W'($urandom_range(0, 61439));
		for (int p = 0; p < 4; p++) begin
			write_base(phase_bases[p]);
			for (int i = 0; i < 85; i++) begin
				if (p == 1 && i == 10)
					hold_requests++;
				send_random();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (pool.errors == 0 && pool.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/idfs_pkg.sv
hdl/idfs_alu.sv
hdl/idfs_store.sv
hdl/id_allocator_free_stack.sv
test/testbench.sv
